>>> rtl/mirror_alpha_blend_row_macros.svh
// Assertion macros for the mirror alpha-blend row block.
// Taken in by the port checker; needs nothing else.
`ifndef MIRROR_ALPHA_BLEND_ROW_MACROS_SVH
`define MIRROR_ALPHA_BLEND_ROW_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define MAB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mab: same-cycle check failed");

// next-cycle implication, quiet while reset is high
`define MAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mab: next-cycle check failed");

// next-cycle implication, checked through reset as well
`define MAB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mab: reset check failed");

`endif

>>> rtl/mab_pkg.sv
// Shared types and constants for the mirror alpha-blend row block.
// No dependencies; used by mab_lane, mab_merge and the top level of the block.
`timescale 1ns / 1ps

package mab_pkg;

   localparam int MAX_ROW_PIXELS_DEF = 1024;
   localparam int RW_W               = 11;
   localparam int ALPHA_W            = 17;
   localparam int PIX_W              = 32;
   localparam int CH_W               = 8;
   localparam int LANES              = 4;
   localparam int CSR_IDX_W          = 1;
   localparam int CSR_DATA_W         = 17;
   localparam int NUM_W              = 27;

   localparam logic [RW_W-1:0]    ROW_WIDTH_RST   = 11'd1024;
   localparam logic [ALPHA_W-1:0] BLEND_ALPHA_RST = 17'd32768;
   // 256 * 65280: smallest numerator that clamps to full scale
   localparam logic [NUM_W-1:0]   CLAMP_NUM       = 27'd16711680;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH   = 1'b0,
      CSR_BLEND_ALPHA = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   typedef struct packed {
      logic valid;
      logic last;
   } beat_ctl_type;

endpackage

>>> rtl/mab_lane.sv
// One channel lane: blend numerator, registered, then divide by 65280 with clamp.
// Depends on mab_pkg.
`timescale 1ns / 1ps

module mab_lane (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic signed [mab_pkg::ALPHA_W-1:0]    blend_alpha,
   input  logic        [mab_pkg::CH_W-1:0]       chan_a,
   input  logic        [mab_pkg::CH_W-1:0]       chan_b,
   output logic        [mab_pkg::CH_W-1:0]       chan_out
);

   logic signed [mab_pkg::CH_W:0]        diff;
   logic signed [mab_pkg::NUM_W-1:0]     prod;
   logic signed [mab_pkg::NUM_W-1:0]     base;
   logic signed [mab_pkg::NUM_W-1:0]     num_in;
   logic signed [mab_pkg::NUM_W-1:0]     num_ff;
   logic        [16:0]                   xp1;
   logic        [24:0]                   recip;

   always_comb begin
      diff   = $signed({1'b0, chan_a}) - $signed({1'b0, chan_b});
      prod   = mab_pkg::NUM_W'(blend_alpha * diff);
      base   = $signed({3'b000, chan_b, 16'h0000}) - $signed({11'h000, chan_b, 8'h00});
      num_in = base + prod;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
      end
   end

   // floor(num/65280) = floor(floor(num/256)/255); x/255 = ((x+1)*257) >> 16 for x < 65280
   always_comb begin
      xp1   = {1'b0, num_ff[23:8]} + 17'd1;
      recip = {xp1, 8'h00} + 25'(xp1);
      if (num_ff[mab_pkg::NUM_W-1]) begin
         chan_out = '0;
      end else if (num_ff >= $signed(mab_pkg::CLAMP_NUM)) begin
         chan_out = '1;
      end else begin
         chan_out = recip[23:16];
      end
   end

endmodule

>>> rtl/mab_merge.sv
// Merge stage: joins the lane results into one pixel and holds the result beat.
// Depends on mab_pkg.
`timescale 1ns / 1ps

module mab_merge (
   input  logic                                              clock,
   input  logic                                              reset,
   input  mab_pkg::beat_ctl_type                             s2_ctl,
   input  logic [mab_pkg::LANES-1:0][mab_pkg::CH_W-1:0]      lane_out,
   output logic                                              advance,
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output logic [mab_pkg::PIX_W-1:0]                         rsp_pixel_out,
   output logic                                              rsp_row_end
);

   logic                        rsp_valid_ff;
   logic [mab_pkg::PIX_W-1:0]   pixel_ff;
   logic                        row_end_ff;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff   <= lane_out;
         row_end_ff <= s2_ctl.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = pixel_ff;
   assign rsp_row_end   = row_end_ff;

endmodule

>>> rtl/mirror_alpha_blend_row.sv
// Top level: ping-pong row store, load/emit control, four channel lanes and merge.
// Depends on mab_pkg, mab_lane, mab_merge.
//
//   port group | dir    | beat carries
//   req_*      | in     | mode, pixel_in (one pixel or one drain beat)
//   rsp_*      | out    | pixel_out, row_end (blended mirrored pixel)
//   csr_*      | in     | index, wdata (row_width, blend_alpha)
//
// One req beat per cycle unless rsp stalls; a result passes the store read, lane
// multiply and merge registers after its req beat. Rate is set by the row store,
// one write port and two read ports each cycle. Reset is synchronous; the
// store is not cleared. A stalled rsp beat holds the whole pipe and req_ready.
`timescale 1ns / 1ps

module mirror_alpha_blend_row #(
   parameter int MAX_ROW_PIXELS = mab_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [mab_pkg::PIX_W-1:0]          req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mab_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic                               rsp_row_end,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mab_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mab_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W  = $clog2(MAX_ROW_PIXELS + 1);
   localparam int ADDR_W = $clog2(2 * MAX_ROW_PIXELS);
   localparam int DEPTH  = 2 * MAX_ROW_PIXELS;
   localparam int CMP_W  = (COL_W > mab_pkg::RW_W) ? COL_W : mab_pkg::RW_W;
   localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_ROW_PIXELS);
   localparam logic [COL_W-1:0]  MAX_COL  = COL_W'(MAX_ROW_PIXELS);
   localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(MAX_ROW_PIXELS);

   logic [mab_pkg::RW_W-1:0]           row_width_ff;
   logic signed [mab_pkg::ALPHA_W-1:0] blend_alpha_ff;
   logic [COL_W-1:0]                   load_column_ff, load_column_in;
   logic [COL_W-1:0]                   emit_column_ff, emit_column_in;
   logic                               load_bank_ff, load_bank_in;
   logic                               row_pending_ff, row_pending_in;

   logic [mab_pkg::PIX_W-1:0]          row_store_mem [DEPTH];
   logic [mab_pkg::PIX_W-1:0]          rd_a_ff, rd_b_ff;

   mab_pkg::beat_ctl_type              s1_ctl_ff, s1_ctl_in, s2_ctl_ff;
   logic [mab_pkg::LANES-1:0][mab_pkg::CH_W-1:0] lane_out;

   logic                               advance;
   logic                               accept;
   logic                               is_pixel;
   logic [CMP_W-1:0]                   rw_ext;
   logic [COL_W-1:0]                   width;
   logic [COL_W-1:0]                   width_m1;
   logic                               emit_go;
   logic                               emit_last;
   logic [COL_W-1:0]                   load_next;
   logic                               row_done;
   logic [ADDR_W-1:0]                  rd_base, addr_a, addr_b, wr_addr;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= mab_pkg::ROW_WIDTH_RST;
         blend_alpha_ff <= mab_pkg::BLEND_ALPHA_RST;
      end else if (csr_valid) begin
         case (mab_pkg::csr_index_type'(csr_index))
            mab_pkg::CSR_ROW_WIDTH:   row_width_ff   <= csr_wdata[mab_pkg::RW_W-1:0];
            mab_pkg::CSR_BLEND_ALPHA: blend_alpha_ff <= csr_wdata[mab_pkg::ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // load / emit control
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign is_pixel  = (req_mode == mab_pkg::MODE_PIXEL);

   always_comb begin
      rw_ext = CMP_W'(row_width_ff);
      if (row_width_ff == '0) begin
         width = COL_W'(1);
      end else if (rw_ext > MAX_CMP) begin
         width = MAX_COL;
      end else begin
         width = COL_W'(rw_ext);
      end
      width_m1  = width - COL_W'(1);
      emit_go   = row_pending_ff && (emit_column_ff < width);
      emit_last = (emit_column_ff == width_m1);
      load_next = load_column_ff + COL_W'(1);
      row_done  = (load_next >= width);
      rd_base   = load_bank_ff ? '0 : BANK_OFS;
      addr_a    = rd_base + ADDR_W'(emit_column_ff);
      addr_b    = rd_base + ADDR_W'(width_m1 - emit_column_ff);
      wr_addr   = (load_bank_ff ? BANK_OFS : '0) + ADDR_W'(load_column_ff);
   end

   always_comb begin
      load_column_in = load_column_ff;
      emit_column_in = emit_column_ff;
      load_bank_in   = load_bank_ff;
      row_pending_in = row_pending_ff;
      if (accept) begin
         if (row_pending_ff) begin
            if (!emit_go || emit_last) begin
               row_pending_in = 1'b0;
            end
            if (emit_go) begin
               emit_column_in = emit_column_ff + COL_W'(1);
            end
         end
         if (is_pixel) begin
            if (row_done) begin
               load_column_in = '0;
               load_bank_in   = !load_bank_ff;
               emit_column_in = '0;
               row_pending_in = 1'b1;
            end else begin
               load_column_in = load_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_column_ff <= '0;
         emit_column_ff <= '0;
         load_bank_ff   <= 1'b0;
         row_pending_ff <= 1'b0;
      end else begin
         load_column_ff <= load_column_in;
         emit_column_ff <= emit_column_in;
         load_bank_ff   <= load_bank_in;
         row_pending_ff <= row_pending_in;
      end
   end

   // row store: one write, two registered reads; the read bank never equals the write bank
   always_ff @(posedge clock) begin
      if (accept && is_pixel) begin
         row_store_mem[wr_addr] <= req_pixel_in;
      end
      if (accept && emit_go) begin
         rd_a_ff <= row_store_mem[addr_a];
         rd_b_ff <= row_store_mem[addr_b];
      end
   end

   // beat control through the pipe
   always_comb begin
      s1_ctl_in.valid = accept && emit_go;
      s1_ctl_in.last  = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   for (genvar k = 0; k < mab_pkg::LANES; k++) begin : g_lane
      mab_lane u_lane (
         .clock       (clock),
         .advance     (advance),
         .blend_alpha (blend_alpha_ff),
         .chan_a      (rd_a_ff[k*mab_pkg::CH_W +: mab_pkg::CH_W]),
         .chan_b      (rd_b_ff[k*mab_pkg::CH_W +: mab_pkg::CH_W]),
         .chan_out    (lane_out[k])
      );
   end

   mab_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .s2_ctl        (s2_ctl_ff),
      .lane_out      (lane_out),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end)
   );

endmodule

>>> rtl/mab_checker.sv
// Port-level checks for mirror_alpha_blend_row, bound to the top level.
// Depends on mirror_alpha_blend_row_macros.svh.
`timescale 1ns / 1ps
`include "mirror_alpha_blend_row_macros.svh"

module mab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel_out,
   input logic        rsp_row_end,
   input logic        csr_valid,
   input logic        csr_ready
);

   logic        rsp_stall;
   logic [32:0] rsp_beat;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_beat  = {rsp_row_end, rsp_pixel_out};

   // a held result beat keeps its payload
   `MAB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_beat))
   // a stalled result stops intake
   `MAB_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_stall, !req_ready)
   // free output side means intake is open
   `MAB_ASSERT_IMPLY(a_req_open, clock, reset, !rsp_stall, req_ready)
   `MAB_ASSERT_IMPLY(a_csr_always_ready, clock, reset, csr_valid, csr_ready)
   `MAB_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind mirror_alpha_blend_row mab_checker u_mab_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_row_end   (rsp_row_end),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready)
);

>>> tb/sv/tb_top.sv
// Self-checking bench for mirror_alpha_blend_row: directed plan, then random phases.
// Predicts the mirrored blend per beat and scores rsp beats in order.
// Needs mab_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
   import mab_pkg::*;

   localparam int     MAX_PIX        = MAX_ROW_PIXELS_DEF;
   localparam longint BLEND_DEN      = 65280;
   localparam int     RANDOM_TARGET  = 870;
   localparam int     CALM_AFTER     = 780;
   localparam int     LONG_HOLD      = 300;
   localparam int     SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
   } blend_beat_type;

   typedef struct {
      bit                    is_reg;
      csr_index_type         reg_idx;
      logic [CSR_DATA_W-1:0] reg_data;
      mode_type              mode;
      logic [PIX_W-1:0]      pixel;
      bit                    typed;
      bit                    typed_has;
      logic [PIX_W-1:0]      typed_pixel;
      bit                    typed_end;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = 1'b0;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_row_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block
   logic [PIX_W-1:0]      row_mem [0:1][0:MAX_PIX-1];
   bit                    row_written [0:1][0:MAX_PIX-1];
   bit                    fill_bank;
   int unsigned           fill_col;
   bit                    row_busy;
   int unsigned           emit_col;
   logic [RW_W-1:0]       width_reg = ROW_WIDTH_RST;
   logic signed [ALPHA_W-1:0] alpha_reg = BLEND_ALPHA_RST;

   blend_beat_type        due_pixels [$];
   plan_row_type          plan [$];

   int  fail_count;
   int  beats_in;
   int  checked;
   int  phases;
   int  widest;
   int  hold_asks;
   bit  calm;
   bit  csr_open;

   mirror_alpha_blend_row u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned eff_width(input logic [RW_W-1:0] w);
      if (w == 0) return 1;
      if (w > MAX_PIX) return MAX_PIX;
      return w;
   endfunction

   function automatic logic [CH_W-1:0] blend_lane(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
      longint num;
      num = longint'(b) * BLEND_DEN + longint'(alpha_reg) * (longint'(a) - longint'(b));
      if (num < 0) return '0;
      if (num / BLEND_DEN > 255) return 8'hFF;
      return CH_W'(num / BLEND_DEN);
   endfunction

   function automatic logic [PIX_W-1:0] blend_bgra(input logic [PIX_W-1:0] pa,
                                                   input logic [PIX_W-1:0] pb);
      logic [PIX_W-1:0] res;
      for (int k = 0; k < LANES; k++)
         res[CH_W*k +: CH_W] = blend_lane(pa[CH_W*k +: CH_W], pb[CH_W*k +: CH_W]);
      return res;
   endfunction

   // emit from the finished bank first, then load into the filling bank
   function automatic bit advance_rows(input mode_type m, input logic [PIX_W-1:0] pix,
                                       output blend_beat_type beat);
      int unsigned w;
      bit          got;
      w = eff_width(width_reg);
      got = 1'b0;
      beat = '0;
      if (row_busy) begin
         if (emit_col >= w) begin
            row_busy = 1'b0;
         end else begin
            beat.pixel   = blend_bgra(row_mem[!fill_bank][emit_col],
                                      row_mem[!fill_bank][w - 1 - emit_col]);
            beat.row_end = (emit_col == w - 1);
            got = 1'b1;
            emit_col++;
            if (emit_col >= w) row_busy = 1'b0;
         end
      end
      if (m == MODE_PIXEL) begin
         row_mem[fill_bank][fill_col]     = pix;
         row_written[fill_bank][fill_col] = 1'b1;
         fill_col++;
         if (fill_col >= w) begin
            fill_bank = !fill_bank;
            fill_col  = 0;
            emit_col  = 0;
            row_busy  = 1'b1;
         end
      end
      return got;
   endfunction

   // a wider setting must not make the pending row read entries never loaded
   function automatic bit grow_is_safe(input logic [RW_W-1:0] w);
      if (!row_busy) return 1'b1;
      for (int unsigned i = 0; i < eff_width(w); i++)
         if (!row_written[!fill_bank][i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [RW_W-1:0] pick_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return '0;
      if (r < 45) return RW_W'($urandom_range(1, 4));
      if (r < 85) return RW_W'($urandom_range(5, 16));
      return RW_W'($urandom_range(17, 48));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_alpha();
      case ($urandom_range(0, 9))
         0:       return 17'h10000;
         1:       return 17'h0FFFF;
         2:       return 17'h00000;
         3:       return 17'h0FF00;
         4:       return 17'h1FFFF;
         5:       return 17'h00100;
         default: return CSR_DATA_W'($urandom_range(0, 17'h1FFFF));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      logic [PIX_W-1:0] v;
      v = $urandom;
      if ($urandom_range(0, 3) == 0)
         for (int k = 0; k < LANES; k++)
            v[CH_W*k +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return v;
   endfunction

   function automatic plan_row_type reg_row(input csr_index_type idx,
                                           input logic [CSR_DATA_W-1:0] d);
      plan_row_type r;
      r = '{default: '0, reg_idx: idx, mode: MODE_PIXEL};
      r.is_reg   = 1'b1;
      r.reg_data = d;
      return r;
   endfunction

   function automatic plan_row_type item_row(input mode_type m, input logic [PIX_W-1:0] p,
                                            input bit typed, input bit t_has,
                                            input logic [PIX_W-1:0] t_pix, input bit t_end);
      plan_row_type r;
      r = '{default: '0, reg_idx: CSR_ROW_WIDTH, mode: m};
      r.pixel       = p;
      r.typed       = typed;
      r.typed_has   = t_has;
      r.typed_pixel = t_pix;
      r.typed_end   = t_end;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                  input logic [PIX_W-1:0] want);
      fail_count++;
      if (fail_count <= 30)
         $display("error: %s: got %h, want %h at %0t", what, got, want, $time);
   endtask

   task automatic send_item(input mode_type m, input logic [PIX_W-1:0] p, input bit typed,
                            input bit t_has, input logic [PIX_W-1:0] t_pix,
                            input bit t_end);
      blend_beat_type beat;
      bit             got;
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_pixel_in <= p;
      do @(posedge clock); while (!req_ready);
      got = advance_rows(m, p, beat);
      if (typed) begin
         got          = t_has;
         beat.pixel   = t_pix;
         beat.row_end = t_end;
      end
      if (got) due_pixels.push_back(beat);
      beats_in++;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (due_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ROW_WIDTH) begin
         width_reg = d[RW_W-1:0];
         phases++;
         if (eff_width(width_reg) > widest) widest = eff_width(width_reg);
      end else begin
         alpha_reg = d;
      end
   endtask

   task automatic apply_settings(input logic [RW_W-1:0] w, input logic [CSR_DATA_W-1:0] a);
      settle_block();
      write_reg(CSR_ROW_WIDTH, {6'($urandom_range(0, 63)), w});
      write_reg(CSR_BLEND_ALPHA, a);
      csr_valid <= 1'b0;
   endtask

   // scoreboard
   always @(posedge clock) begin
      blend_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_pixels.size() == 0) begin
            report_mismatch("rsp beat with nothing due", rsp_pixel_out, '0);
         end else begin
            want = due_pixels.pop_front();
            checked++;
            if (rsp_pixel_out !== want.pixel)
               report_mismatch("pixel_out", rsp_pixel_out, want.pixel);
            if (rsp_row_end !== want.row_end)
               report_mismatch("row_end", PIX_W'(rsp_row_end), PIX_W'(want.row_end));
         end
      end
   end

   // receiver: random stall bursts, one long hold on request
   initial begin
      int holds_served;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_served) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < 8) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #1_000_000;
      $display("timeout: %0d beats in, %0d still due", beats_in, due_pixels.size());
      $display("mirror_alpha_blend_row: mismatch");
      $finish;
   end

   initial begin
      int                    n;
      int                    ppct;
      int                    rand_base;
      int                    directed_beats;
      logic [RW_W-1:0]       w_pick;
      logic [CSR_DATA_W-1:0] a_pick;
      bit                    hold_done;
      bit                    hold_now;
      bit                    wide_done;
      bit                    pause_done;
      mode_type              m;

      fill_bank = 1'b0;
      fill_col  = 0;
      row_busy  = 1'b0;
      emit_col  = 0;
      foreach (row_written[b, i]) row_written[b][i] = 1'b0;

      // at reset width; nothing pending
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 1, 0, 32'h0, 0));
      // width 0 acts as 1: a pixel blends with itself
      plan.push_back(reg_row(CSR_ROW_WIDTH, 17'd0));
      plan.push_back(reg_row(CSR_BLEND_ALPHA, 17'h0FF00));
      plan.push_back(item_row(MODE_PIXEL, 32'hFFFFFFFF, 1, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_PIXEL, 32'h00000000, 1, 1, 32'hFFFFFFFF, 1));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 1, 1, 32'h00000000, 1));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 1, 0, 32'h0, 0));
      // zero alpha picks the mirror pixel
      plan.push_back(reg_row(CSR_ROW_WIDTH, 17'd2));
      plan.push_back(reg_row(CSR_BLEND_ALPHA, 17'h00000));
      plan.push_back(item_row(MODE_PIXEL, 32'hFF00FF00, 1, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_PIXEL, 32'h00FF00FF, 1, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 1, 1, 32'h00FF00FF, 0));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 1, 1, 32'hFF00FF00, 1));
      // max alpha overshoots and clamps
      plan.push_back(reg_row(CSR_ROW_WIDTH, 17'd4));
      plan.push_back(reg_row(CSR_BLEND_ALPHA, 17'h0FFFF));
      plan.push_back(item_row(MODE_PIXEL, 32'hFF00FF00, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_PIXEL, 32'h00FF00FF, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_PIXEL, 32'h80407F01, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_PIXEL, 32'h01FEC0A5, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 0, 0, 32'h0, 0));
      // shrink under the emit column: pending row ends silently
      plan.push_back(reg_row(CSR_ROW_WIDTH, 17'd0));
      plan.push_back(item_row(MODE_PIXEL, 32'h3C5AA5C3, 1, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 1, 1, 32'h3C5AA5C3, 1));
      // min alpha; shrink under the load column, then drain wider than loaded
      plan.push_back(reg_row(CSR_ROW_WIDTH, 17'd4));
      plan.push_back(reg_row(CSR_BLEND_ALPHA, 17'h10000));
      plan.push_back(item_row(MODE_PIXEL, 32'h11223344, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_PIXEL, 32'hF0E1D2C3, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_PIXEL, 32'h7F80FF00, 0, 0, 32'h0, 0));
      plan.push_back(reg_row(CSR_ROW_WIDTH, 17'd2));
      plan.push_back(item_row(MODE_PIXEL, 32'hA5A5A5A5, 0, 0, 32'h0, 0));
      plan.push_back(reg_row(CSR_ROW_WIDTH, 17'd4));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 0, 0, 32'h0, 0));
      plan.push_back(item_row(MODE_DRAIN, 32'h0, 0, 0, 32'h0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            if (!csr_open) settle_block();
            write_reg(plan[i].reg_idx, plan[i].reg_data);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_valid <= 1'b0;
               csr_open = 1'b0;
            end
            send_item(plan[i].mode, plan[i].pixel, plan[i].typed, plan[i].typed_has,
                      plan[i].typed_pixel, plan[i].typed_end);
         end
      end
      directed_beats = beats_in;

      rand_base = beats_in;
      while (beats_in - rand_base < RANDOM_TARGET) begin
         calm     = (beats_in - rand_base >= CALM_AFTER);
         w_pick   = pick_width();
         a_pick   = pick_alpha();
         hold_now = 1'b0;
         if (calm) begin
            // closing stretch keeps the current settings, no idling
            n    = RANDOM_TARGET - (beats_in - rand_base);
            ppct = 75;
         end else if (!hold_done && beats_in - rand_base >= 300) begin
            w_pick    = RW_W'(2);
            n         = 80;
            ppct      = 100;
            hold_done = 1'b1;
            hold_now  = 1'b1;
         end else if (!wide_done && beats_in - rand_base >= 450) begin
            // past full width: clamps to the store size, row stays open
            w_pick    = RW_W'($urandom_range(MAX_PIX + 1, 2047));
            n         = 60;
            ppct      = 90;
            wide_done = 1'b1;
         end else begin
            n = eff_width(w_pick) * $urandom_range(1, 3)
                + $urandom_range(0, eff_width(w_pick) + 2);
            case ($urandom_range(0, 3))
               0:       ppct = 100;
               1:       ppct = 85;
               2:       ppct = 60;
               default: ppct = 35;
            endcase
         end
         if (!calm) begin
            while (!grow_is_safe(w_pick)) send_item(MODE_DRAIN, pick_pixel(), 0, 0, '0, 0);
            apply_settings(w_pick, a_pick);
         end
         if (hold_now) hold_asks++;
         for (int i = 0; i < n; i++) begin
            if (!pause_done && beats_in - rand_base >= 550) begin
               pause_done = 1'b1;
               req_valid <= 1'b0;
               while (due_pixels.size() != 0) @(posedge clock);
               @(posedge clock);
            end else if (!calm && $urandom_range(0, 99) < 12) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 11)) @(posedge clock);
            end
            if ($urandom_range(0, 99) < ppct) m = MODE_PIXEL;
            else m = MODE_DRAIN;
            send_item(m, pick_pixel(), 0, 0, '0, 0);
         end
      end

      req_valid <= 1'b0;
      for (int k = 0; k < 50000 && due_pixels.size() != 0; k++) @(posedge clock);
      repeat (12) @(posedge clock);
      if (due_pixels.size() != 0)
         report_mismatch("pixels never returned", PIX_W'(due_pixels.size()), '0);

      $display("covered %0d req beats (%0d directed), %0d blended pixels checked",
               beats_in, directed_beats, checked);
      $display("over %0d width settings up to %0d pixels, alpha extremes, long rsp hold",
               phases, widest);
      if (fail_count == 0) begin
         $display("mirror_alpha_blend_row: match");
      end else begin
         $display("mirror_alpha_blend_row: mismatch");
      end
      $finish;
   end

endmodule
